>>> sv/safm_pkg.sv
// shared types and constants for the sprite animation frame timer
`default_nettype none

package safm_pkg;

  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int DELAY_W   = 15;
  localparam int SPEED_W   = 15;
  localparam int COUNT_W   = 11;
  localparam int FRAME_W   = 10;
  localparam int TIMER_W   = 16;
  localparam int CMP_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd5;

  typedef struct packed {
    logic               enable;
    logic               fixed_mode;
    logic [DELAY_W-1:0] fixed_delay;
    logic [SPEED_W-1:0] speed;
    logic [COUNT_W-1:0] frame_count;
    logic [INDEX_W-1:0] loop_start;
  } safm_cfg_t;

endpackage

`default_nettype wire

>>> sv/safm_delay_ram.sv
// frame delay table: one write port, one registered read port
`default_nettype none

module safm_delay_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [safm_pkg::DELAY_W-1:0] wr_data,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [safm_pkg::DELAY_W-1:0] rd_data
);

  logic [safm_pkg::DELAY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> sv/safm_engine.sv
// request sequencer: timer accumulate, frame stepping with table reads, result register
`default_nettype none

module safm_engine #(
  parameter int MAX_FRAMES = 1024,
  parameter int AW         = 10,
  parameter int FW         = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire safm_pkg::safm_cfg_t           cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [safm_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [safm_pkg::INDEX_W-1:0]  in_entry_index,
  input  wire logic [safm_pkg::DELAY_W-1:0]  in_entry_delay,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [safm_pkg::FRAME_W-1:0]       out_frame_index,
  output logic [safm_pkg::TIMER_W-1:0]       out_timer_value,
  output logic                               out_wrapped,
  output logic                               out_stalled,
  output logic                               ram_wr_en,
  output logic [AW-1:0]                      ram_wr_addr,
  output logic [safm_pkg::DELAY_W-1:0]       ram_wr_data,
  output logic [AW-1:0]                      ram_rd_addr,
  input  wire logic [safm_pkg::DELAY_W-1:0]  ram_rd_data
);

  localparam int CW = safm_pkg::CMP_W;
  localparam int TW = safm_pkg::TIMER_W;
  localparam int DW = safm_pkg::DELAY_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_LOAD_T = 3'd2;
  localparam logic [2:0] ST_LOAD_R = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [DW-1:0] cur_r, cur_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          stalled_r, stalled_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [safm_pkg::FRAME_W-1:0] out_frame_r;
  logic [TW-1:0] out_timer_r;
  logic          out_wrapped_r, out_stalled_r;

  logic          in_acc;
  logic          out_load;
  logic [DW-1:0] use_delay;
  logic [CW-1:0] max_c, fc_ext, eff_n;
  logic [CW-1:0] frame_ext, frame_inc, loop_ext, loop_sel, idx_ext, rst_sel, nxt_ext;
  logic          wrap_hit;
  logic [TW:0]   sum_ext;

  assign max_c     = CW'(MAX_FRAMES);
  assign fc_ext    = {{(CW-safm_pkg::COUNT_W){1'b0}}, cfg.frame_count};
  assign eff_n     = (fc_ext > max_c) ? max_c : fc_ext;
  assign frame_ext = {{(CW-FW){1'b0}}, frame_r};
  assign frame_inc = frame_ext + CW'(1);
  assign wrap_hit  = (frame_inc >= eff_n);
  assign loop_ext  = {{(CW-safm_pkg::INDEX_W){1'b0}}, cfg.loop_start};
  assign loop_sel  = (loop_ext < eff_n) ? loop_ext : '0;
  assign idx_ext   = {{(CW-safm_pkg::INDEX_W){1'b0}}, in_entry_index};
  assign rst_sel   = (idx_ext < eff_n) ? idx_ext : '0;
  assign use_delay = cfg.fixed_mode ? cfg.fixed_delay : cur_r;
  assign sum_ext   = {1'b0, timer_r} + {{(TW+1-safm_pkg::SPEED_W){1'b0}}, cfg.speed};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign ram_wr_en   = in_acc && (in_kind == safm_pkg::KIND_WRITE) && (idx_ext < max_c);
  assign ram_wr_addr = idx_ext[AW-1:0];
  assign ram_wr_data = in_entry_delay;
  // the table is read at the frame being entered; data lands in the load state
  assign nxt_ext     = {{(CW-FW){1'b0}}, frame_nxt};
  assign ram_rd_addr = nxt_ext[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    frame_nxt   = frame_r;
    timer_nxt   = timer_r;
    cur_nxt     = cur_r;
    wrapped_nxt = wrapped_r;
    stalled_nxt = stalled_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wrapped_nxt = 1'b0;
          stalled_nxt = 1'b0;
          case (in_kind)
            safm_pkg::KIND_TICK: begin
              if (cfg.enable) begin
                timer_nxt = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
                state_nxt = ST_CHECK;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            safm_pkg::KIND_RESTART: begin
              frame_nxt = rst_sel[FW-1:0];
              timer_nxt = '0;
              state_nxt = ST_LOAD_R;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CHECK: begin
        if (use_delay == '0) begin
          stalled_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (timer_r < {1'b0, use_delay}) begin
          state_nxt = ST_DONE;
        end else begin
          timer_nxt = timer_r - {1'b0, use_delay};
          frame_nxt = wrap_hit ? loop_sel[FW-1:0] : frame_inc[FW-1:0];
          if (wrap_hit) begin
            wrapped_nxt = 1'b1;
          end
          state_nxt = ST_LOAD_T;
        end
      end
      ST_LOAD_T: begin
        cur_nxt   = ram_rd_data;
        state_nxt = ST_CHECK;
      end
      ST_LOAD_R: begin
        cur_nxt   = ram_rd_data;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_r     <= '0;
      timer_r     <= '0;
      cur_r       <= '0;
      wrapped_r   <= 1'b0;
      stalled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      timer_r     <= timer_nxt;
      cur_r       <= cur_nxt;
      wrapped_r   <= wrapped_nxt;
      stalled_r   <= stalled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r   <= frame_ext[safm_pkg::FRAME_W-1:0];
      out_timer_r   <= timer_r;
      out_wrapped_r <= wrapped_r;
      out_stalled_r <= stalled_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_r;
  assign out_timer_value = out_timer_r;
  assign out_wrapped     = out_wrapped_r;
  assign out_stalled     = out_stalled_r;

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD_T |=> state_r == ST_CHECK)
    else $error("table load did not return to check");

  a_zero_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && use_delay == '0) |=> (state_r == ST_DONE && stalled_r))
    else $error("zero delay did not stop the tick");

  a_advance_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && use_delay != '0 && timer_r >= {1'b0, use_delay})
    |=> timer_r == $past(timer_r - {1'b0, use_delay}))
    else $error("advance did not subtract the delay");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> state_r == ST_DONE)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

>>> sv/sprite_animation_frame_timer.sv
// top level: configuration registers, request sequencer and delay table
// sequence: write, disabled tick or unknown kind go straight to the result; restart reads the table once;
//   enabled tick accumulates, then steps frames with one table read per step
// throughput: one request at a time; the next is taken once its
//   predecessor's result has been registered, the result register freeing the output side
// reset: synchronous active-low rst_n clears frame, timer and latched delay and returns
//   config to its defaults; the delay table itself is not cleared and holds nothing until written
`default_nettype none

module sprite_animation_frame_timer #(
  parameter int MAX_FRAMES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [safm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [safm_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [safm_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [safm_pkg::INDEX_W-1:0]   in_entry_index,
  input  wire logic [safm_pkg::DELAY_W-1:0]   in_entry_delay,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [safm_pkg::FRAME_W-1:0]        out_frame_index,
  output logic [safm_pkg::TIMER_W-1:0]        out_timer_value,
  output logic                                out_wrapped,
  output logic                                out_stalled
);

  // table address width, and frame width capped by the 11-bit frame count
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW = (AW < safm_pkg::COUNT_W) ? AW : safm_pkg::COUNT_W;

  safm_pkg::safm_cfg_t cfg_r, cfg_nxt;

  logic                         ram_wr_en;
  logic [AW-1:0]                ram_wr_addr;
  logic [safm_pkg::DELAY_W-1:0] ram_wr_data;
  logic [AW-1:0]                ram_rd_addr;
  logic [safm_pkg::DELAY_W-1:0] ram_rd_data;

  // register file decode; writes past the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        safm_pkg::REG_ENABLE:      cfg_nxt.enable      = cfg_wdata[0];
        safm_pkg::REG_FIXED_MODE:  cfg_nxt.fixed_mode  = cfg_wdata[0];
        safm_pkg::REG_FIXED_DELAY: cfg_nxt.fixed_delay = cfg_wdata[safm_pkg::DELAY_W-1:0];
        safm_pkg::REG_SPEED:       cfg_nxt.speed       = cfg_wdata[safm_pkg::SPEED_W-1:0];
        safm_pkg::REG_FRAME_COUNT: cfg_nxt.frame_count = cfg_wdata[safm_pkg::COUNT_W-1:0];
        safm_pkg::REG_LOOP_START:  cfg_nxt.loop_start  = cfg_wdata[safm_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.fixed_mode  <= 1'b0;
      cfg_r.fixed_delay <= safm_pkg::DELAY_W'(1);
      cfg_r.speed       <= safm_pkg::SPEED_W'(1);
      cfg_r.frame_count <= safm_pkg::COUNT_W'(1);
      cfg_r.loop_start  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: accumulate, then step frames while the timer covers a nonzero delay
  safm_engine #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW),
    .FW         (FW)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_entry_delay  (in_entry_delay),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_index (out_frame_index),
    .out_timer_value (out_timer_value),
    .out_wrapped     (out_wrapped),
    .out_stalled     (out_stalled),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data)
  );

  // per-frame delays, read at the frame being entered through the registered read port
  safm_delay_ram #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire
